FILE: rtl/core/assert_macros.svh
// Assertion helpers, included by the region picker unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/lurp_pkg.sv
package lurp_pkg;

   // Width of every address and length field.
   localparam int FIELD_W = 48;

   // Page shift register.
   localparam int PAGE_SHIFT_W = 5;
   localparam logic [PAGE_SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_PAGE_SHIFT  = 2'd0;
   localparam csr_idx_type CSR_INITRD_BASE = 2'd1;
   localparam csr_idx_type CSR_INITRD_SIZE = 2'd2;

   typedef logic [FIELD_W-1:0] addr_type;
   typedef logic [FIELD_W:0]   wide_addr_type;

endpackage

FILE: rtl/core/largest_usable_region_picker_unit.sv
// Channel  | Direction | Handshake               | Payload
// req_     | in        | req_valid / req_stall   | region_start, region_length, usable, last_entry
// rsp_     | out       | rsp_valid / rsp_stall   | found, chosen_base, chosen_size
// csr_     | in        | csr_write               | csr_index, csr_data
//
// One entry is taken every cycle unless req_stall holds it; a result passes the stage
// registers (ramdisk cut, page alignment, then trim and compare) into the output register.
// The rate is set by the three-stage pipeline, whose stages can all advance at once.
// Reset is synchronous and active high; it clears valid bits, the running best
// and the configuration (page shift 12, no ramdisk exclusion).
// Only a last entry waits on rsp_stall; entries that give no result keep flowing
// while a finished result sits in the output register.
`include "assert_macros.svh"

module largest_usable_region_picker_unit #(
   parameter int ADDR_BITS = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lurp_pkg::FIELD_W-1:0]       req_region_start,
   input  logic [lurp_pkg::FIELD_W-1:0]       req_region_length,
   input  logic                               req_usable,
   input  logic                               req_last_entry,
   // Result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [lurp_pkg::FIELD_W-1:0]       rsp_chosen_base,
   output logic [lurp_pkg::FIELD_W-1:0]       rsp_chosen_size,
   // Configuration port
   input  logic                               csr_write,
   input  logic [lurp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lurp_pkg::FIELD_W-1:0]       csr_data
);

   localparam int W = lurp_pkg::FIELD_W;

   // Highest address that the map may use. Above the field width the
   // field itself is the limit.
   localparam lurp_pkg::addr_type ADDR_LIMIT = (ADDR_BITS >= W) ? {W{1'b1}} :
      W'((64'd1 << ADDR_BITS) - 64'd1);
   localparam lurp_pkg::wide_addr_type ADDR_LIMIT_WIDE = {1'b0, ADDR_LIMIT};

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [lurp_pkg::PAGE_SHIFT_W-1:0] page_shift_ff;
   lurp_pkg::addr_type                initrd_base_ff;
   lurp_pkg::addr_type                initrd_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff  <= lurp_pkg::PAGE_SHIFT_RESET;
         initrd_base_ff <= '0;
         initrd_size_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lurp_pkg::CSR_PAGE_SHIFT:
               page_shift_ff <= csr_data[lurp_pkg::PAGE_SHIFT_W-1:0];
            lurp_pkg::CSR_INITRD_BASE: initrd_base_ff <= csr_data;
            lurp_pkg::CSR_INITRD_SIZE: initrd_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The page size and its mask follow the page shift register.
   lurp_pkg::addr_type page_bytes;
   lurp_pkg::addr_type page_mask;
   lurp_pkg::wide_addr_type initrd_end;

   assign page_bytes = W'(1) << page_shift_ff;
   assign page_mask  = page_bytes - W'(1);
   assign initrd_end = {1'b0, initrd_base_ff} + {1'b0, initrd_size_ff};

   // ---------------------------------------------------------------------
   // Flow control. Only the last stage is held directly, and only by a last
   // entry that meets a stalled, occupied output; earlier stages back up behind it.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s3_last_ff;
   logic rsp_valid_ff;
   logic out_free, s1_move, s2_move, s3_move, req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_move   = s3_valid_ff && (!s3_last_ff || out_free);
   assign s2_move   = s2_valid_ff && (!s3_valid_ff || s3_move);
   assign s1_move   = s1_valid_ff && (!s2_valid_ff || s2_move);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (req_take || s1_move) s1_valid_ff <= req_take;
         if (s1_move || s2_move)  s2_valid_ff <= s1_move;
         if (s2_move || s3_move)  s3_valid_ff <= s2_move;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: input register and ramdisk cut
   // ---------------------------------------------------------------------
   lurp_pkg::addr_type s1_start_ff, s1_len_ff;
   logic               s1_usable_ff, s1_last_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_start_ff  <= req_region_start;
         s1_len_ff    <= req_region_length;
         s1_usable_ff <= req_usable;
         s1_last_ff   <= req_last_entry;
      end
   end

   lurp_pkg::wide_addr_type region_end, suffix_len;
   lurp_pkg::addr_type      prefix_len;
   logic                    entry_ok, overlaps;
   logic                    s2_ok_in;
   lurp_pkg::addr_type      s2_start_in, s2_len_in;

   always_comb begin
      entry_ok   = s1_usable_ff && (s1_len_ff != '0) &&
                   (s1_start_ff <= ADDR_LIMIT) && (s1_len_ff <= ADDR_LIMIT);
      region_end = {1'b0, s1_start_ff} + {1'b0, s1_len_ff};
      overlaps   = (initrd_size_ff != '0) &&
                   !(({1'b0, initrd_base_ff} >= region_end) ||
                     (initrd_end <= {1'b0, s1_start_ff}));
      prefix_len = (initrd_base_ff > s1_start_ff) ? (initrd_base_ff - s1_start_ff) : '0;
      suffix_len = (initrd_end < region_end) ? (region_end - initrd_end) : '0;

      s2_ok_in    = entry_ok;
      s2_start_in = s1_start_ff;
      s2_len_in   = s1_len_ff;
      if (overlaps) begin
         // Keep the larger side of the ramdisk; the piece before it wins ties.
         if (({1'b0, prefix_len} >= suffix_len) && (prefix_len != '0) &&
             (prefix_len <= ADDR_LIMIT)) begin
            s2_len_in = prefix_len;
         end else if ((suffix_len != '0) && (suffix_len <= ADDR_LIMIT_WIDE) &&
                      (initrd_end <= ADDR_LIMIT_WIDE)) begin
            s2_start_in = initrd_end[W-1:0];
            s2_len_in   = suffix_len[W-1:0];
         end else begin
            s2_ok_in = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: round the start up to a page boundary
   // ---------------------------------------------------------------------
   logic               s2_ok_ff, s2_last_ff;
   lurp_pkg::addr_type s2_start_ff, s2_len_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_ok_ff    <= s2_ok_in;
         s2_last_ff  <= s1_last_ff;
         s2_start_ff <= s2_start_in;
         s2_len_ff   <= s2_len_in;
      end
   end

   lurp_pkg::wide_addr_type aligned_start, align_gap;
   logic                    s3_ok_in;
   lurp_pkg::addr_type      s3_rem_in;

   always_comb begin
      aligned_start = ({1'b0, s2_start_ff} + {1'b0, page_mask}) & ~{1'b0, page_mask};
      align_gap     = aligned_start - {1'b0, s2_start_ff};
      s3_ok_in      = s2_ok_ff && (aligned_start <= ADDR_LIMIT_WIDE) &&
                      (align_gap < {1'b0, s2_len_ff});
      s3_rem_in     = s2_len_ff - align_gap[W-1:0];
   end

   // ---------------------------------------------------------------------
   // Stage 3: trim to whole pages and compare against the running best
   // ---------------------------------------------------------------------
   logic               s3_ok_ff;
   lurp_pkg::addr_type s3_start_ff, s3_rem_ff;

   always_ff @(posedge clock) begin
      if (s2_move) begin
         s3_ok_ff    <= s3_ok_in;
         s3_last_ff  <= s2_last_ff;
         s3_start_ff <= aligned_start[W-1:0];
         s3_rem_ff   <= s3_rem_in;
      end
   end

   lurp_pkg::addr_type best_start_ff, best_len_ff;
   lurp_pkg::addr_type trimmed_len, best_start_in, best_len_in;
   logic               take_piece;

   always_comb begin
      trimmed_len   = s3_rem_ff & ~page_mask;
      take_piece    = s3_ok_ff && (trimmed_len >= page_bytes) && (trimmed_len > best_len_ff);
      best_start_in = take_piece ? s3_start_ff : best_start_ff;
      best_len_in   = take_piece ? trimmed_len : best_len_ff;
   end

   // The running best is cleared once a last entry has reported it.
   always_ff @(posedge clock) begin
      if (reset) begin
         best_start_ff <= '0;
         best_len_ff   <= '0;
      end else if (s3_move) begin
         if (s3_last_ff) begin
            best_start_ff <= '0;
            best_len_ff   <= '0;
         end else begin
            best_start_ff <= best_start_in;
            best_len_ff   <= best_len_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic               emit;
   logic               rsp_found_ff;
   lurp_pkg::addr_type rsp_base_ff, rsp_size_ff;

   assign emit = s3_move && s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff <= (best_len_in != '0);
         rsp_base_ff  <= (best_len_in != '0) ? best_start_in : '0;
         rsp_size_ff  <= best_len_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_chosen_base = rsp_base_ff;
   assign rsp_chosen_size = rsp_size_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // A finished result never lands on one that is still waiting.
   `ASSERT_IMPL(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !emit)
   // Reporting a map shows the result and starts the next map from nothing.
   `ASSERT_NEXT(a_emit_clears, clock, reset, emit,
                rsp_valid_ff && (best_len_ff == '0) && (best_start_ff == '0))
   // A not-found result carries zero fields.
   `ASSERT_IMPL(a_empty_zero, clock, reset, rsp_valid_ff && !rsp_found_ff,
                (rsp_base_ff == '0) && (rsp_size_ff == '0))
   // A found result always carries a nonzero size.
   `ASSERT_IMPL(a_found_size, clock, reset, rsp_valid_ff && rsp_found_ff,
                rsp_size_ff != '0)

endmodule
